### design/sbb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbb_pkg
// Shared types and constants of the separable 5x5 binomial blur core.
// ----------------------------------------------------------------------------
package sbb_pkg;

   localparam int MAX_WIDTH    = 2048;
   localparam int MAX_HEIGHT   = 4096;
   localparam int SAMPLE_BITS  = 16;
   localparam int MIN_DIM      = 5;

   localparam int COL_BITS     = $clog2(MAX_WIDTH);
   localparam int IN_ROW_BITS  = $clog2(MAX_HEIGHT + 2);
   localparam int OUT_ROW_BITS = $clog2(MAX_HEIGHT);
   localparam int WIDTH_BITS   = $clog2(MAX_WIDTH + 1);
   localparam int HEIGHT_BITS  = $clog2(MAX_HEIGHT + 1);

   localparam int NUM_SLOTS    = 4;
   localparam int SLOT_BITS    = $clog2(NUM_SLOTS);
   localparam int WINDOW_DEPTH = 4;
   localparam int DELAY_DEPTH  = 2;

   localparam int KERNEL_SHIFT = 8;
   localparam int VSUM_BITS    = SAMPLE_BITS + KERNEL_SHIFT / 2;
   localparam int HSUM_BITS    = SAMPLE_BITS + KERNEL_SHIFT;
   localparam int ROUND_HALF   = 1 << (KERNEL_SHIFT - 1);

   localparam int CFG_WIDTH_BITS  = 12;
   localparam int CFG_HEIGHT_BITS = 13;
   localparam int CSR_DATA_BITS   = 13;
   localparam int CSR_INDEX_BITS  = 1;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_WIDTH  = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_HEIGHT = 1'd1;

   localparam logic ACTION_SAMPLE = 1'b0;
   localparam logic ACTION_FLUSH  = 1'b1;

   typedef struct packed {
      logic                   action;
      logic [SAMPLE_BITS-1:0] in_sample;
   } req_beat_type;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] out_sample;
      logic                   end_of_line;
      logic                   end_of_frame;
   } rsp_beat_type;

   typedef struct packed {
      logic                 vert;
      logic                 emit;
      logic                 eol;
      logic                 eof;
      logic                 interior;
      logic [SLOT_BITS-1:0] slot;
   } item_ctrl_type;

endpackage
`default_nettype wire

### design/sbb_row_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbb_row_ram
// One line slot: simple dual-port memory, one write and one registered read.
// ----------------------------------------------------------------------------
module sbb_row_ram (
   input  wire logic                           clock,
   input  wire logic                           wr_en,
   input  wire logic [sbb_pkg::COL_BITS-1:0]    wr_addr,
   input  wire logic [sbb_pkg::SAMPLE_BITS-1:0] wr_data,
   input  wire logic                           rd_en,
   input  wire logic [sbb_pkg::COL_BITS-1:0]    rd_addr,
   output      logic [sbb_pkg::SAMPLE_BITS-1:0] rd_data
);
   import sbb_pkg::*;

   logic [SAMPLE_BITS-1:0] mem_ff [MAX_WIDTH];
   logic [SAMPLE_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

### design/sbb_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbb_ctrl
// Frame size registers and raster counters; classifies each accepted beat.
// ----------------------------------------------------------------------------
module sbb_ctrl (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_write_en,
   input  wire logic [sbb_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [sbb_pkg::CSR_DATA_BITS-1:0]  csr_data,
   input  wire logic                              req_valid,
   input  wire sbb_pkg::req_beat_type             req_data,
   input  wire logic                              s1_ready,
   output      logic                              item_valid,
   output      sbb_pkg::item_ctrl_type            item_ctrl,
   output      logic [sbb_pkg::COL_BITS-1:0]       item_col,
   output      logic [sbb_pkg::SAMPLE_BITS-1:0]    item_sample,
   output      logic                              wr_en
);
   import sbb_pkg::*;

   logic [COL_BITS-1:0]     in_col_ff, in_col_in;
   logic [IN_ROW_BITS-1:0]  in_row_ff, in_row_in;
   logic [COL_BITS-1:0]     out_col_ff, out_col_in;
   logic [OUT_ROW_BITS-1:0] out_row_ff, out_row_in;
   logic [WIDTH_BITS-1:0]   width_ff, width_in;
   logic [HEIGHT_BITS-1:0]  height_ff, height_in;

   logic [CFG_WIDTH_BITS-1:0]  raw_width;
   logic [CFG_HEIGHT_BITS-1:0] raw_height;
   logic                       accept;
   logic                       in_frame;
   logic                       real_sample;
   logic                       ignore;
   logic                       emit;
   logic                       eol;
   logic                       eof;
   logic                       interior;
   logic                       col_last;

   assign raw_width  = csr_data[CFG_WIDTH_BITS-1:0];
   assign raw_height = csr_data[CFG_HEIGHT_BITS-1:0];

   always_comb begin
      accept      = req_valid && s1_ready;
      in_frame    = in_row_ff < IN_ROW_BITS'(height_ff);
      ignore      = (req_data.action == ACTION_FLUSH) && in_frame;
      real_sample = (req_data.action == ACTION_SAMPLE) && in_frame;
      emit        = (in_row_ff > IN_ROW_BITS'(2))
                    || ((in_row_ff == IN_ROW_BITS'(2)) && (in_col_ff >= COL_BITS'(2)));
      eol         = WIDTH_BITS'(out_col_ff) == (width_ff - WIDTH_BITS'(1));
      eof         = eol && (HEIGHT_BITS'(out_row_ff) == (height_ff - HEIGHT_BITS'(1)));
      interior    = (out_row_ff >= OUT_ROW_BITS'(2))
                    && ((HEIGHT_BITS'(out_row_ff) + HEIGHT_BITS'(2)) < height_ff)
                    && (out_col_ff >= COL_BITS'(2))
                    && ((WIDTH_BITS'(out_col_ff) + WIDTH_BITS'(2)) < width_ff);
      col_last    = (WIDTH_BITS'(in_col_ff) + WIDTH_BITS'(1)) >= width_ff;

      item_valid         = accept && !ignore;
      wr_en              = accept && real_sample;
      item_col           = in_col_ff;
      item_sample        = req_data.in_sample;
      item_ctrl.vert     = real_sample && (in_row_ff >= IN_ROW_BITS'(4));
      item_ctrl.emit     = emit;
      item_ctrl.eol      = eol;
      item_ctrl.eof      = eof;
      item_ctrl.interior = interior;
      item_ctrl.slot     = in_row_ff[SLOT_BITS-1:0];
   end

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write_en && (csr_index == CSR_FRAME_WIDTH)) begin
         if (raw_width < CFG_WIDTH_BITS'(MIN_DIM)) begin
            width_in = WIDTH_BITS'(MIN_DIM);
         end else if (raw_width > CFG_WIDTH_BITS'(MAX_WIDTH)) begin
            width_in = WIDTH_BITS'(MAX_WIDTH);
         end else begin
            width_in = WIDTH_BITS'(raw_width);
         end
      end
      if (csr_write_en && (csr_index == CSR_FRAME_HEIGHT)) begin
         if (raw_height < CFG_HEIGHT_BITS'(MIN_DIM)) begin
            height_in = HEIGHT_BITS'(MIN_DIM);
         end else if (raw_height > CFG_HEIGHT_BITS'(MAX_HEIGHT)) begin
            height_in = HEIGHT_BITS'(MAX_HEIGHT);
         end else begin
            height_in = HEIGHT_BITS'(raw_height);
         end
      end
   end

   always_comb begin
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (csr_write_en || (item_valid && emit && eof)) begin
         in_col_in  = '0;
         in_row_in  = '0;
         out_col_in = '0;
         out_row_in = '0;
      end else if (item_valid) begin
         if (emit) begin
            if (eol) begin
               out_col_in = '0;
               out_row_in = out_row_ff + OUT_ROW_BITS'(1);
            end else begin
               out_col_in = out_col_ff + COL_BITS'(1);
            end
         end
         if (col_last) begin
            in_col_in = '0;
            in_row_in = in_row_ff + IN_ROW_BITS'(1);
         end else begin
            in_col_in = in_col_ff + COL_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         width_ff   <= WIDTH_BITS'(MAX_WIDTH);
         height_ff  <= HEIGHT_BITS'(MAX_HEIGHT);
      end else begin
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
         width_ff   <= width_in;
         height_ff  <= height_in;
      end
   end

endmodule
`default_nettype wire

### design/sbb_vsum.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbb_vsum
// Line slots and vertical [1 4 6 4 1] sum over the current column.
// ----------------------------------------------------------------------------
module sbb_vsum (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           item_valid,
   input  wire sbb_pkg::item_ctrl_type         item_ctrl,
   input  wire logic [sbb_pkg::COL_BITS-1:0]    item_col,
   input  wire logic [sbb_pkg::SAMPLE_BITS-1:0] item_sample,
   input  wire logic                           wr_en,
   input  wire logic                           s2_ready,
   output      logic                           s1_ready,
   output      logic                           s1_valid,
   output      sbb_pkg::item_ctrl_type         s1_ctrl,
   output      logic [sbb_pkg::VSUM_BITS-1:0]   s1_vsum,
   output      logic [sbb_pkg::SAMPLE_BITS-1:0] s1_center
);
   import sbb_pkg::*;

   logic                   s1_valid_ff, s1_valid_in;
   item_ctrl_type          s1_ctrl_ff;
   logic [SAMPLE_BITS-1:0] s1_sample_ff;
   logic [SAMPLE_BITS-1:0] rd_data [NUM_SLOTS];
   logic [SAMPLE_BITS-1:0] tap1, tap2, tap3, tap4;
   logic [VSUM_BITS-1:0]   sum;

   for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_slot
      sbb_row_ram u_ram (
         .clock   (clock),
         .wr_en   (wr_en && (item_ctrl.slot == SLOT_BITS'(g))),
         .wr_addr (item_col),
         .wr_data (item_sample),
         .rd_en   (item_valid),
         .rd_addr (item_col),
         .rd_data (rd_data[g])
      );
   end

   always_comb begin
      s1_ready    = !s1_valid_ff || s2_ready;
      s1_valid_in = s1_ready ? item_valid : s1_valid_ff;
   end

   // taps of the four lines above, oldest last
   always_comb begin
      tap1 = rd_data[s1_ctrl_ff.slot - SLOT_BITS'(1)];
      tap2 = rd_data[s1_ctrl_ff.slot - SLOT_BITS'(2)];
      tap3 = rd_data[s1_ctrl_ff.slot - SLOT_BITS'(3)];
      tap4 = rd_data[s1_ctrl_ff.slot];
      sum  = VSUM_BITS'(tap4)
             + (VSUM_BITS'(tap3) << 2)
             + (VSUM_BITS'(tap2) << 2) + (VSUM_BITS'(tap2) << 1)
             + (VSUM_BITS'(tap1) << 2)
             + VSUM_BITS'(s1_sample_ff);
      s1_vsum   = s1_ctrl_ff.vert ? sum : '0;
      s1_center = tap2;
      s1_valid  = s1_valid_ff;
      s1_ctrl   = s1_ctrl_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_ctrl_ff   <= item_ctrl;
         s1_sample_ff <= item_sample;
      end
   end

endmodule
`default_nettype wire

### design/sbb_hsum.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbb_hsum
// Column-sum window, horizontal [1 4 6 4 1] sum, rounding and result register.
// ----------------------------------------------------------------------------
module sbb_hsum (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_write_en,
   input  wire logic                           s1_valid,
   input  wire sbb_pkg::item_ctrl_type         s1_ctrl,
   input  wire logic [sbb_pkg::VSUM_BITS-1:0]   s1_vsum,
   input  wire logic [sbb_pkg::SAMPLE_BITS-1:0] s1_center,
   output      logic                           s2_ready,
   output      logic                           rsp_valid,
   input  wire logic                           rsp_stall,
   output      sbb_pkg::rsp_beat_type          rsp_data
);
   import sbb_pkg::*;

   logic                   s2_valid_ff, s2_valid_in;
   item_ctrl_type          s2_ctrl_ff;
   logic [VSUM_BITS-1:0]   s2_vsum_ff;
   logic [SAMPLE_BITS-1:0] s2_border_ff;
   logic [SAMPLE_BITS-1:0] delay_ff [DELAY_DEPTH];
   logic [VSUM_BITS-1:0]   win_ff [WINDOW_DEPTH];
   logic [VSUM_BITS-1:0]   win_in [WINDOW_DEPTH];
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_beat_type           rsp_data_ff, rsp_data_in;
   logic                   out_ready;
   logic                   s2_leave;
   logic [HSUM_BITS-1:0]   hsum;

   always_comb begin
      out_ready   = !rsp_valid_ff || !rsp_stall;
      s2_ready    = !s2_valid_ff || !s2_ctrl_ff.emit || out_ready;
      s2_leave    = s2_valid_ff && s2_ready;
      s2_valid_in = s2_ready ? s1_valid : s2_valid_ff;
   end

   always_comb begin
      hsum = HSUM_BITS'(win_ff[3])
             + (HSUM_BITS'(win_ff[2]) << 2)
             + (HSUM_BITS'(win_ff[1]) << 2) + (HSUM_BITS'(win_ff[1]) << 1)
             + (HSUM_BITS'(win_ff[0]) << 2)
             + HSUM_BITS'(s2_vsum_ff)
             + HSUM_BITS'(ROUND_HALF);
      rsp_data_in.out_sample   = s2_ctrl_ff.interior ? hsum[KERNEL_SHIFT +: SAMPLE_BITS]
                                                     : s2_border_ff;
      rsp_data_in.end_of_line  = s2_ctrl_ff.eol;
      rsp_data_in.end_of_frame = s2_ctrl_ff.eof;
      rsp_valid_in = out_ready ? (s2_valid_ff && s2_ctrl_ff.emit) : rsp_valid_ff;
   end

   // window clears at frame end and on every frame size write
   always_comb begin
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
         win_in[i] = win_ff[i];
      end
      if (csr_write_en || (s2_leave && s2_ctrl_ff.eof)) begin
         for (int i = 0; i < WINDOW_DEPTH; i++) begin
            win_in[i] = '0;
         end
      end else if (s2_leave) begin
         win_in[0] = s2_vsum_ff;
         for (int i = 1; i < WINDOW_DEPTH; i++) begin
            win_in[i] = win_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < WINDOW_DEPTH; i++) begin
            win_ff[i] <= '0;
         end
      end else begin
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < WINDOW_DEPTH; i++) begin
            win_ff[i] <= win_in[i];
         end
      end
   end

   // border sample is the center line tap of two beats earlier
   always_ff @(posedge clock) begin
      if (s2_ready) begin
         s2_ctrl_ff   <= s1_ctrl;
         s2_vsum_ff   <= s1_vsum;
         s2_border_ff <= delay_ff[DELAY_DEPTH-1];
      end
      if (s1_valid && s2_ready) begin
         delay_ff[0] <= s1_center;
         for (int i = 1; i < DELAY_DEPTH; i++) begin
            delay_ff[i] <= delay_ff[i-1];
         end
      end
      if (out_ready) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

### design/separable_binomial_blur_5x5_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// separable_binomial_blur_5x5_core
// 5x5 binomial blur of a raster frame, vertical then horizontal, border kept.
//
//   port group | dir | beat contents
//   req_*      | in  | action, in_sample (flush beats drain the last results)
//   rsp_*      | out | out_sample, end_of_line, end_of_frame
//   csr_*      | in  | frame_width (index 0), frame_height (index 1)
//
// one beat per cycle while req_stall is low; a taken beat passes s1, s2 and rsp
// (line slot read into s1 at the taking edge, vertical sum into s2, horizontal sum into rsp)
// results trail their input by two lines and two pixels of the raster
// reset is synchronous; line slots are not cleared and need no sweep
// a stalled result holds rsp and backs up into req only when all stages fill
// ----------------------------------------------------------------------------
module separable_binomial_blur_5x5_core (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output      logic                              req_stall,
   input  wire sbb_pkg::req_beat_type             req_data,
   output      logic                              rsp_valid,
   input  wire logic                              rsp_stall,
   output      sbb_pkg::rsp_beat_type             rsp_data,
   input  wire logic                              csr_write_en,
   input  wire logic [sbb_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [sbb_pkg::CSR_DATA_BITS-1:0]  csr_data
);
   import sbb_pkg::*;

   logic                   item_valid;
   item_ctrl_type          item_ctrl;
   logic [COL_BITS-1:0]    item_col;
   logic [SAMPLE_BITS-1:0] item_sample;
   logic                   wr_en;
   logic                   s1_ready;
   logic                   s1_valid;
   item_ctrl_type          s1_ctrl;
   logic [VSUM_BITS-1:0]   s1_vsum;
   logic [SAMPLE_BITS-1:0] s1_center;
   logic                   s2_ready;

   assign req_stall = !s1_ready;

   sbb_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .req_valid    (req_valid),
      .req_data     (req_data),
      .s1_ready     (s1_ready),
      .item_valid   (item_valid),
      .item_ctrl    (item_ctrl),
      .item_col     (item_col),
      .item_sample  (item_sample),
      .wr_en        (wr_en)
   );

   sbb_vsum u_vsum (
      .clock       (clock),
      .reset       (reset),
      .item_valid  (item_valid),
      .item_ctrl   (item_ctrl),
      .item_col    (item_col),
      .item_sample (item_sample),
      .wr_en       (wr_en),
      .s2_ready    (s2_ready),
      .s1_ready    (s1_ready),
      .s1_valid    (s1_valid),
      .s1_ctrl     (s1_ctrl),
      .s1_vsum     (s1_vsum),
      .s1_center   (s1_center)
   );

   sbb_hsum u_hsum (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .s1_valid     (s1_valid),
      .s1_ctrl      (s1_ctrl),
      .s1_vsum      (s1_vsum),
      .s1_center    (s1_center),
      .s2_ready     (s2_ready),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data)
   );

   a_no_stall_when_drained : assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || !rsp_stall) |-> !req_stall)
      else $error("input stalled while the result register can take a beat");

   a_stall_needs_item : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid)
      else $error("input stalled with an empty first stage");

   a_frame_end_is_line_end : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.end_of_frame) |-> rsp_data.end_of_line)
      else $error("frame end flagged away from a line end");

endmodule
`default_nettype wire
